// ===== src/hsle_pkg.sv =====
// shared types and codes for the hash set lookup engine
package hsle_pkg;

    // operation codes on the action field
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TEST   = 2'd2;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;

    // controller to datapath
    typedef struct packed {
        logic clear;   // zero one valid row
        logic accept;  // capture request and read its bucket row
        logic commit;  // write back the row and load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is on its last row
        logic out_free;    // result register can take a beat
    } t_sts;

endpackage

// ===== src/hsle_if.sv =====
// request and response channel interfaces

interface hsle_req_if import hsle_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface hsle_rsp_if;
    logic valid;
    logic ready;
    logic was_present;
    logic overflow;

    modport source (output valid, output was_present, output overflow, input ready);
    modport sink   (input valid, input was_present, input overflow, output ready);
endinterface

// ===== src/hsle_ctrl.sv =====
// controller state machine: clearing pass, request accept, write-back
module hsle_ctrl import hsle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/hsle_dpath.sv =====
// datapath: bucket row memories, way compare, row update, result register
module hsle_dpath import hsle_pkg::*; #(
    parameter int BUCKETS  = 1024,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [KEY_W-1:0]    i_key,
    output t_sts                o_sts,
    hsle_rsp_if.source          o_rsp
);

    localparam int BW = $clog2(BUCKETS);
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    // memories, one row per bucket
    logic [WAYS-1:0]    r_valid_mem [BUCKETS];
    logic [WAYS*KW-1:0] r_key_mem   [BUCKETS];

    logic [BW-1:0]       r_clr_cnt;
    logic [BW-1:0]       r_bucket;
    logic [ACTION_W-1:0] r_action;
    logic [KW-1:0]       r_key;
    logic [WAYS-1:0]     r_vrow;
    logic [WAYS*KW-1:0]  r_krow;

    logic                r_out_valid;
    logic                r_was_present;
    logic                r_overflow;

    logic [KW-1:0]       w_key_m;
    logic [BW+KW-1:0]    w_key_ext;
    logic [BW-1:0]       w_bucket;
    logic [WAYS-1:0]     w_hit;
    logic [WAYS-1:0]     w_hit_oh;
    logic [WAYS-1:0]     w_free_oh;
    logic                w_any_hit;
    logic                w_any_free;
    logic                w_do_add;
    logic [WAYS-1:0]     w_vrow_new;
    logic [WAYS*KW-1:0]  w_krow_new;
    logic [BW-1:0]       w_vaddr;
    logic                w_vwe;
    logic [WAYS-1:0]     w_vdata;

    // key masked to its used width, bucket = its low BW bits
    assign w_key_m   = i_key[KW-1:0];
    assign w_key_ext = {{BW{1'b0}}, w_key_m};
    assign w_bucket  = w_key_ext[BW-1:0];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_hit[w] = r_vrow[w] && (r_krow[w*KW +: KW] == r_key);
        end
    end

    // lowest matching way and lowest free way
    assign w_hit_oh   = w_hit & (~w_hit + WAYS'(1));
    assign w_free_oh  = ~r_vrow & (r_vrow + WAYS'(1));
    assign w_any_hit  = |w_hit;
    assign w_any_free = |w_free_oh;
    assign w_do_add   = (r_action == ACT_ADD) && !w_any_hit && w_any_free;

    always_comb begin
        w_vrow_new = r_vrow;
        if (w_do_add) begin
            w_vrow_new = r_vrow | w_free_oh;
        end else if ((r_action == ACT_REMOVE) && w_any_hit) begin
            w_vrow_new = r_vrow & ~w_hit_oh;
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_krow_new[w*KW +: KW] = w_free_oh[w] ? r_key : r_krow[w*KW +: KW];
        end
    end

    assign w_vwe   = i_cmd.clear || i_cmd.commit;
    assign w_vaddr = i_cmd.clear ? r_clr_cnt : r_bucket;
    assign w_vdata = i_cmd.clear ? '0 : w_vrow_new;

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_valid_mem[w_vaddr] <= w_vdata;
        end
        if (i_cmd.accept) begin
            r_vrow <= r_valid_mem[w_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_do_add) begin
            r_key_mem[r_bucket] <= w_krow_new;
        end
        if (i_cmd.accept) begin
            r_krow <= r_key_mem[w_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bucket <= w_bucket;
            r_action <= i_action;
            r_key    <= w_key_m;
        end
        if (i_cmd.commit) begin
            r_was_present <= w_any_hit;
            r_overflow    <= (r_action == ACT_ADD) && !w_any_hit && !w_any_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + BW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == BW'(BUCKETS - 1));
    assign o_sts.out_free   = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.was_present = r_was_present;
    assign o_rsp.overflow    = r_overflow;

endmodule

// ===== src/hash_set_lookup_engine_top.sv =====
// top level of the hash set lookup engine
// a request beat accepted in the idle state has its bucket row read into registers;
// the evaluate state then writes the row back and loads the response register, and
//   no new request is taken before that; a full response register stalls the write-back
// reset: synchronous active low; afterwards a clearing pass zeroes one valid row per
//   cycle until all BUCKETS rows are clear, during which no request beat is taken
module hash_set_lookup_engine_top import hsle_pkg::*; #(
    parameter int BUCKETS  = 1024,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsle_req_if.sink   i_req,
    hsle_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    // controller sequences clear, accept and commit
    hsle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_req_ready (w_ready),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_ready;

    // datapath holds bucket rows and the response register
    hsle_dpath #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_action (i_req.action),
        .i_key    (i_req.key),
        .o_sts    (w_sts),
        .o_rsp    (o_rsp)
    );

    // one request in flight: no new beat right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one in flight");

    // a dropped add never reports the key as present
    a_ovf_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.overflow && o_rsp.was_present))
        else $error("overflow and was_present both set");

    // a write-back always presents a response beat
    a_commit_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_rsp.valid)
        else $error("commit without response beat");

    // at most one of clear, accept and commit in any cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear, w_cmd.accept, w_cmd.commit}))
        else $error("conflicting datapath commands");

endmodule
